// File: sv/r2p_pkg.sv
// Package for the rectangular-to-polar converter: widths, payload types and CORDIC constants.
package r2p_pkg;

  // Field width of coordinates, radius and angle.
  localparam int COORD_WIDTH = 16;
  // Requested number of micro-rotations.
  localparam int ITERATIONS  = 16;
  // Fraction bits carried through the datapath.
  localparam int GUARD       = 16;
  // Largest number of micro-rotations the angle table covers.
  localparam int MAX_STAGES  = 32;
  // Micro-rotations actually built.
  localparam int ITER = (ITERATIONS > MAX_STAGES) ? MAX_STAGES : ITERATIONS;
  // Datapath width: sign, growth headroom, integer part and guard fraction.
  localparam int DP_WIDTH = COORD_WIDTH + GUARD + 3;

  // Inverse CORDIC gain in the limit, scaled by 2^32.
  localparam logic [63:0] INV_GAIN_LIMIT = 64'd2608131496;

  // Per-stage arctangents as 32-bit binary angles (2^31 is pi), rounded to nearest.
  localparam logic [31:0] ATAN_STEP [0:MAX_STAGES-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Quadrant pre-rotation angles.
  localparam logic [31:0] ANGLE_ZERO     = 32'h00000000;
  localparam logic [31:0] ANGLE_PLUS_90  = 32'h40000000;
  localparam logic [31:0] ANGLE_MINUS_90 = 32'hC0000000;

  // Raise the limit inverse gain by the factor of every stage that is not built.
  function automatic logic [63:0] inv_gain_f(int stages);
    logic [63:0] k;
    k = INV_GAIN_LIMIT;
    for (int i = MAX_STAGES - 1; i >= stages; i--) begin
      k = k + (k >> (2 * i + 1));
    end
    return k;
  endfunction

  // Inverse gain for the built stage count, scaled by 2^32.
  localparam logic [31:0] INV_GAIN = 32'(inv_gain_f(ITER));

  // One Cartesian point.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
  } point_t;

  // One polar result.
  typedef struct packed {
    logic        [COORD_WIDTH-1:0] radius;
    logic signed [COORD_WIDTH-1:0] angle;
  } polar_t;

  // Result of the rotation pipeline handed to the scaling stages.
  typedef struct packed {
    logic signed [DP_WIDTH-1:0] x;
    logic        [31:0]         z;
    logic                       origin;
  } vec_t;

endpackage

// File: sv/r2p_cordic.sv
// Quadrant pre-rotation and the pipelined CORDIC vectoring micro-rotations.
module r2p_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            point_valid,
  output logic            point_ready,
  input  r2p_pkg::point_t point,
  output logic            vec_valid,
  input  logic            vec_ready,
  output r2p_pkg::vec_t   vec
);

  localparam int W  = r2p_pkg::DP_WIDTH;
  localparam int CW = r2p_pkg::COORD_WIDTH;
  localparam int N  = r2p_pkg::ITER;

  // Stage 0 holds the pre-rotated point; stage k holds the result of micro-rotation k-1.
  logic        [N:0]   v_q;
  logic        [N:0]   org_q;
  logic signed [W-1:0] x_q [0:N];
  logic signed [W-1:0] y_q [0:N];
  logic        [31:0]  z_q [0:N];

  logic signed [W-1:0] x_n [0:N];
  logic signed [W-1:0] y_n [0:N];
  logic        [31:0]  z_n [0:N];
  logic        [N:0]   org_n;
  logic        [N+1:0] rdy;

  logic signed [W-1:0] x_ext;
  logic signed [W-1:0] y_ext;

  // A stage takes new data when it is empty or its content moves on.
  always_comb begin
    rdy[N+1] = vec_ready;
    for (int k = N; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign point_ready = rdy[0];

  // Pre-rotate points of the left half plane by plus or minus 90 degrees, then apply
  // one micro-rotation per stage, each with its own fixed shift, driving y toward zero.
  always_comb begin
    x_ext    = {{(W-CW){point.x_coord[CW-1]}}, point.x_coord};
    y_ext    = {{(W-CW){point.y_coord[CW-1]}}, point.y_coord};
    org_n[0] = (point.x_coord == '0) && (point.y_coord == '0);
    x_n[0]   = x_ext <<< r2p_pkg::GUARD;
    y_n[0]   = y_ext <<< r2p_pkg::GUARD;
    z_n[0]   = r2p_pkg::ANGLE_ZERO;
    if (x_ext[W-1]) begin
      if (y_ext[W-1]) begin
        x_n[0] = (-y_ext) <<< r2p_pkg::GUARD;
        y_n[0] = x_ext <<< r2p_pkg::GUARD;
        z_n[0] = r2p_pkg::ANGLE_MINUS_90;
      end else begin
        x_n[0] = y_ext <<< r2p_pkg::GUARD;
        y_n[0] = (-x_ext) <<< r2p_pkg::GUARD;
        z_n[0] = r2p_pkg::ANGLE_PLUS_90;
      end
    end
    for (int k = 1; k <= N; k++) begin
      org_n[k] = org_q[k-1];
      if (!y_q[k-1][W-1]) begin
        x_n[k] = x_q[k-1] + (y_q[k-1] >>> (k - 1));
        y_n[k] = y_q[k-1] - (x_q[k-1] >>> (k - 1));
        z_n[k] = z_q[k-1] + r2p_pkg::ATAN_STEP[k-1];
      end else begin
        x_n[k] = x_q[k-1] - (y_q[k-1] >>> (k - 1));
        y_n[k] = y_q[k-1] + (x_q[k-1] >>> (k - 1));
        z_n[k] = z_q[k-1] - r2p_pkg::ATAN_STEP[k-1];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= point_valid;
      end
      for (int k = 1; k <= N; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage data registers load whenever their stage may advance.
  always_ff @(posedge clk) begin
    for (int k = 0; k <= N; k++) begin
      if (rdy[k]) begin
        x_q[k]   <= x_n[k];
        y_q[k]   <= y_n[k];
        z_q[k]   <= z_n[k];
        org_q[k] <= org_n[k];
      end
    end
  end

  assign vec_valid  = v_q[N];
  assign vec.x      = x_q[N];
  assign vec.z      = z_q[N];
  assign vec.origin = org_q[N];

  // After pre-rotation x is never negative.
  a_prerot_x_nonneg: assert property (@(posedge clk) disable iff (rst)
    v_q[0] |-> !x_q[0][W-1])
    else $error("pre-rotated x is negative");

  // Pre-rotation only ever starts from one of three quadrant angles.
  a_prerot_angle: assert property (@(posedge clk) disable iff (rst)
    v_q[0] |-> (z_q[0] == r2p_pkg::ANGLE_ZERO) || (z_q[0] == r2p_pkg::ANGLE_PLUS_90) ||
               (z_q[0] == r2p_pkg::ANGLE_MINUS_90))
    else $error("unexpected pre-rotation angle");

  // Any point other than the origin ends with a positive x.
  a_final_x_pos: assert property (@(posedge clk) disable iff (rst)
    v_q[N] && !org_q[N] |-> (x_q[N] > 0))
    else $error("final x is not positive");

  // A stalled last stage keeps its item.
  a_last_stage_hold: assert property (@(posedge clk) disable iff (rst)
    v_q[N] && !vec_ready |=> v_q[N] && $stable(x_q[N]) && $stable(z_q[N]))
    else $error("stalled rotation result changed");

endmodule

// File: sv/r2p_scale.sv
// Gain compensation of the magnitude, angle rounding and the output register.
module r2p_scale (
  input  logic            clk,
  input  logic            rst,
  input  logic            vec_valid,
  output logic            vec_ready,
  input  r2p_pkg::vec_t   vec,
  output logic            polar_valid,
  input  logic            polar_ready,
  output r2p_pkg::polar_t polar
);

  localparam int W  = r2p_pkg::DP_WIDTH;
  localparam int CW = r2p_pkg::COORD_WIDTH;
  localparam int S  = 32 - CW;
  localparam logic [63:0] HALF    = 64'd1 << (r2p_pkg::GUARD - 1);
  localparam logic [63:0] RAD_MAX = (64'd1 << CW) - 64'd1;

  // Valid bits of stages A (low product), B (high product) and C (output).
  logic va, vb, vc;
  logic rdy_a, rdy_b, rdy_c;

  logic [31:0]   hi_a;
  logic [63:0]   lo_prod_a;
  logic [CW-1:0] ang_a;
  logic [63:0]   hi_prod_b;
  logic [31:0]   lo_hi_b;
  logic [CW-1:0] ang_b;
  logic [CW-1:0] radius_q;
  logic [CW-1:0] angle_q;

  logic [W-1:0]  mag;
  logic [63:0]   mag64;
  logic [33:0]   ang_sum;
  logic [CW-1:0] ang_n;
  logic [63:0]   sum;
  logic [63:0]   rad;
  logic [CW-1:0] rad_n;

  assign rdy_c     = !vc || polar_ready;
  assign rdy_b     = !vb || rdy_c;
  assign rdy_a     = !va || rdy_b;
  assign vec_ready = rdy_a;

  // Clamp negative x, split the magnitude into 32-bit halves, and round the angle.
  always_comb begin
    mag     = vec.x[W-1] ? '0 : vec.x;
    mag64   = {{(64-W){1'b0}}, mag};
    ang_sum = {1'b0, vec.z, 1'b0} + (34'd1 << S);
    ang_n   = vec.origin ? '0 : ang_sum[S+1 +: CW];
  end

  // Sum the partial products, round at the integer and saturate.
  always_comb begin
    sum   = hi_prod_b + {32'd0, lo_hi_b};
    rad   = (sum + HALF) >> r2p_pkg::GUARD;
    rad_n = (rad > RAD_MAX) ? RAD_MAX[CW-1:0] : rad[CW-1:0];
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (rdy_a) begin
        va <= vec_valid;
      end
      if (rdy_b) begin
        vb <= va;
      end
      if (rdy_c) begin
        vc <= vb;
      end
    end
  end

  // Stage A: low half times the inverse gain; stage B: high half; stage C: result.
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      hi_a      <= mag64[63:32];
      lo_prod_a <= {32'd0, mag64[31:0]} * {32'd0, r2p_pkg::INV_GAIN};
      ang_a     <= ang_n;
    end
    if (rdy_b) begin
      hi_prod_b <= {32'd0, hi_a} * {32'd0, r2p_pkg::INV_GAIN};
      lo_hi_b   <= lo_prod_a[63:32];
      ang_b     <= ang_a;
    end
    if (rdy_c) begin
      radius_q <= rad_n;
      angle_q  <= ang_b;
    end
  end

  assign polar_valid  = vc;
  assign polar.radius = radius_q;
  assign polar.angle  = angle_q;

  // A waiting result is held until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    vc && !polar_ready |=> vc && $stable(radius_q) && $stable(angle_q))
    else $error("pending result changed");

  // The origin leaves the rotation pipeline with zero magnitude and gets angle zero.
  a_origin_angle: assert property (@(posedge clk) disable iff (rst)
    vec_valid && vec.origin && rdy_a |=> (ang_a == '0) && (lo_prod_a == '0) && (hi_a == '0))
    else $error("origin did not give a zero result");

  // The high product stage passes on what stage A held.
  a_stage_b_load: assert property (@(posedge clk) disable iff (rst)
    va && rdy_b |=> vb && (ang_b == $past(ang_a)))
    else $error("stage B lost an item");

endmodule

// File: sv/rect_to_polar.sv
// Top level of the pipelined CORDIC rectangular-to-polar converter.
//
//   channel  direction  payload                  handshake
//   point    in         x_coord, y_coord         point_valid / point_ready
//   polar    out        radius, angle            polar_valid / polar_ready
//
// One point is taken per cycle while no stall holds the input; a result passes the
// pre-rotation register, which loads at the transfer edge, then one stage per
// micro-rotation and three stages for the gain multiply and rounding.
// Reset clears only the valid bits of all stages; the data registers are not reset.
// A stall holds each full stage whose successor cannot move; empty stages keep filling,
// so new points are taken until every stage is occupied.
module rect_to_polar (
  input  logic            clk,
  input  logic            rst,
  input  logic            point_valid,
  output logic            point_ready,
  input  r2p_pkg::point_t point,
  output logic            polar_valid,
  input  logic            polar_ready,
  output r2p_pkg::polar_t polar
);

  logic          vec_valid;
  logic          vec_ready;
  r2p_pkg::vec_t vec;

  // Pre-rotation and micro-rotations.
  r2p_cordic u_cordic (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point),
    .vec_valid   (vec_valid),
    .vec_ready   (vec_ready),
    .vec         (vec)
  );

  // Gain compensation, rounding and output register.
  r2p_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .vec_valid   (vec_valid),
    .vec_ready   (vec_ready),
    .vec         (vec),
    .polar_valid (polar_valid),
    .polar_ready (polar_ready),
    .polar       (polar)
  );

endmodule
